// ===== hdl/sfd_pkg.sv =====
// shared types, codes and constants for the sensor frame deframer
`default_nettype none

package sfd_pkg;

	// number of serial links with their own parser state
	localparam int unsigned CHANNELS = 2;

	localparam logic [7:0] StartByteReset  = 8'd250;
	localparam logic [7:0] BusIdReset      = 8'd255;
	localparam logic [7:0] MaxPayloadReset = 8'd254;

	typedef enum logic [1:0] {
		REG_START_BYTE  = 2'd0,
		REG_BUS_ID      = 2'd1,
		REG_MAX_PAYLOAD = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_START = 3'd1,
		PH_BID   = 3'd2,
		PH_MID   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CSUM  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EV_CONSUMED = 2'd0,
		EV_PAYLOAD  = 2'd1,
		EV_GOOD     = 2'd2,
		EV_REJECT   = 2'd3
	} event_t;

	typedef struct packed {
		logic       channel;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic       out_channel;
		logic [1:0] event_res;
		logic [7:0] message_id;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       last;
	} out_t;

	// one channel's parser state as held in the state ram
	typedef struct packed {
		phase_t     phase;
		logic [7:0] running_sum;
		logic [7:0] message_id;
		logic [7:0] frame_length;
		logic [7:0] byte_count;
	} entry_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] bus_id;
		logic [7:0] max_payload;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/sfd_parse_step.sv =====
// next-state and result logic for one received byte on one channel
`default_nettype none

module sfd_parse_step
	import sfd_pkg::*;
(
	input  var cfg_t   cfg,
	input  var in_t    item,
	input  var entry_t cur,
	output entry_t     nxt,
	output out_t       res
);

	logic [7:0] sum;
	logic [8:0] cnt_inc;
	event_t     ev;
	logic [7:0] pbyte;
	logic [7:0] pidx;
	logic       plast;

	assign sum     = cur.running_sum + item.data_byte;
	assign cnt_inc = {1'b0, cur.byte_count} + 9'd1;

	always_comb begin
		nxt   = cur;
		ev    = EV_CONSUMED;
		pbyte = 8'd0;
		pidx  = 8'd0;
		plast = 1'b0;
		unique case (cur.phase)
			PH_START: begin
				nxt.running_sum = sum;
				if (item.data_byte != cfg.bus_id) begin
					ev        = EV_REJECT;
					nxt.phase = PH_HUNT;
				end else begin
					nxt.phase = PH_BID;
				end
			end
			PH_BID: begin
				nxt.running_sum = sum;
				nxt.message_id  = item.data_byte;
				nxt.phase       = PH_MID;
			end
			PH_MID: begin
				nxt.running_sum  = sum;
				nxt.frame_length = item.data_byte;
				nxt.byte_count   = 8'd0;
				if (item.data_byte > cfg.max_payload) begin
					ev        = EV_REJECT;
					nxt.phase = PH_HUNT;
				end else if (item.data_byte == 8'd0) begin
					// empty payload, next byte is the checksum
					nxt.phase = PH_CSUM;
				end else begin
					nxt.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				ev              = EV_PAYLOAD;
				pbyte           = item.data_byte;
				pidx            = cur.byte_count;
				nxt.running_sum = sum;
				nxt.byte_count  = cnt_inc[7:0];
				if (cnt_inc >= {1'b0, cur.frame_length}) begin
					plast     = 1'b1;
					nxt.phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				nxt.running_sum = sum;
				ev              = (sum == 8'd0) ? EV_GOOD : EV_REJECT;
				nxt.phase       = PH_HUNT;
			end
			default: begin
				// hunting, and phase codes without meaning
				if (item.data_byte == cfg.start_byte) begin
					nxt.phase        = PH_START;
					nxt.running_sum  = 8'd0;
					nxt.message_id   = 8'd0;
					nxt.frame_length = 8'd0;
					nxt.byte_count   = 8'd0;
				end else begin
					nxt.phase = PH_HUNT;
				end
			end
		endcase
	end

	always_comb begin
		res.out_channel    = item.channel;
		res.event_res      = ev;
		res.message_id     = nxt.message_id;
		res.payload_length = nxt.frame_length;
		res.payload_byte   = pbyte;
		res.payload_index  = pidx;
		res.last           = plast;
	end

endmodule

`default_nettype wire

// ===== hdl/sensor_frame_deframer_unit.sv =====
// top level of the sensor frame deframer: channel state ram, parse stage, result register
`default_nettype none

// Per-channel frame parser for start/bus-id/message-id/length/payload/checksum
// frames. Each request carries one byte and the link it came from; each byte
// gives exactly one result: consumed, payload byte (with index and last mark),
// frame good or frame rejected. The block takes one byte per clock cycle
// while the result side keeps up, via the parse stage and result register.
// The channel's state ram entry is read on accept, updated and written back
// as the parse stage advances; a byte on the same channel right behind it
// takes the updated entry from a bypass register. The ram needs no clearing
// pass: a valid flop per channel, cleared by reset, makes an unwritten entry
// read as the idle hunting state. The result register decouples the two
// sides, so a new request is taken while a result waits. Configuration
// registers must be written only while the block is idle; it is not enforced.

module sensor_frame_deframer_unit
	import sfd_pkg::*;
(
	input  var logic       clk,
	input  var logic       arst_n,
	// configuration write port
	input  var logic       cfg_we,
	input  var logic [1:0] cfg_index,
	input  var logic [7:0] cfg_wdata,
	// byte request channel
	input  var logic       byte_valid,
	output logic           byte_ready,
	input  var in_t        byte_req,
	// result channel
	output logic           result_valid,
	input  var logic       result_ready,
	output out_t           result
);

	// configuration registers
	cfg_t cfg_q;

	// parser state ram and per-entry valid flags
	entry_t               state_mem [CHANNELS];
	logic [CHANNELS-1:0]  ent_vld_q;

	// parse stage
	logic   s1_valid_q;
	in_t    item_s1;
	logic   ch_ok_s1;
	entry_t rd_s1;
	logic   vld_s1;
	logic   byp_s1;
	entry_t byp_data_s1;

	// result register
	logic res_valid_q;
	out_t res_q;

	logic   accept;
	logic   s1_adv;
	logic   wr_en;
	logic   ch_ok;
	entry_t cur;
	entry_t nxt;
	out_t   step_res;
	out_t   res_d;

	assign ch_ok  = {31'd0, byte_req.channel} < CHANNELS;
	assign s1_adv = s1_valid_q && (!res_valid_q || result_ready);
	assign byte_ready = !s1_valid_q || s1_adv;
	assign accept = byte_valid && byte_ready;
	// out-of-range channels leave all state alone
	assign wr_en  = s1_adv && ch_ok_s1;

	// config writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= StartByteReset;
			cfg_q.bus_id      <= BusIdReset;
			cfg_q.max_payload <= MaxPayloadReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BYTE:  cfg_q.start_byte  <= cfg_wdata;
				REG_BUS_ID:      cfg_q.bus_id      <= cfg_wdata;
				REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// state ram: write back from the parse stage, registered read on accept
	always_ff @(posedge clk) begin
		if (wr_en) begin
			state_mem[item_s1.channel] <= nxt;
		end
		if (accept) begin
			rd_s1 <= state_mem[byte_req.channel];
		end
	end

	// entry valid flags, set on first write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[item_s1.channel] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage payload; the bypass catches a write back to the same channel
	// landing on the edge where this request's read is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= byte_req;
			ch_ok_s1    <= ch_ok;
			vld_s1      <= ch_ok && ent_vld_q[byte_req.channel];
			byp_s1      <= wr_en && (item_s1.channel == byte_req.channel);
			byp_data_s1 <= nxt;
		end
	end

	// current entry: bypass first, then ram, unwritten entries read as idle
	always_comb begin
		if (byp_s1) begin
			cur = byp_data_s1;
		end else if (vld_s1) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
	end

	sfd_parse_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (cur),
		.nxt  (nxt),
		.res  (step_res)
	);

	// a channel with no parser gives a bare consumed result
	always_comb begin
		if (ch_ok_s1) begin
			res_d = step_res;
		end else begin
			res_d             = '0;
			res_d.out_channel = item_s1.channel;
			res_d.event_res   = EV_CONSUMED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// payload index always lies inside the declared length
	a_index_in_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_res == EV_PAYLOAD)
		|-> (result.payload_index < result.payload_length))
		else $error("payload index outside declared length");

	// last mark only on payload bytes
	a_last_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> (result.event_res == EV_PAYLOAD))
		else $error("last mark on a non-payload result");

	// a frame end always sends the channel back to hunting
	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && ((step_res.event_res == EV_GOOD) || (step_res.event_res == EV_REJECT))
		|-> (nxt.phase == PH_HUNT))
		else $error("frame end without return to hunting");

	// an accepted request always occupies the parse stage next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted request lost before parse stage");

endmodule

`default_nettype wire
